FILE: sv/dv64_pkg.sv
package dv64_pkg;

    // width of the division datapath; the stream ports stay at IO_W
    localparam int DW   = 64;
    localparam int IO_W = 64;

    localparam logic [1:0] MODE_SQUO = 2'd0;
    localparam logic [1:0] MODE_SREM = 2'd1;
    localparam logic [1:0] MODE_UQUO = 2'd2;
    localparam logic [1:0] MODE_UREM = 2'd3;

    typedef logic [DW-1:0] word_t;

    // control that travels with every beat through the pipe
    typedef struct packed {
        logic valid;
        logic sel_rem;
        logic neg;
    } ctl_t;

endpackage

FILE: sv/dv64_prep.sv
module dv64_prep (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    ce,
    input  logic                    in_valid,
    input  logic [dv64_pkg::IO_W-1:0] dividend,
    input  logic [dv64_pkg::IO_W-1:0] divisor,
    input  logic [1:0]              mode,
    output dv64_pkg::word_t         num_reg,
    output dv64_pkg::word_t         den_reg,
    output dv64_pkg::ctl_t          ctl_reg
);

    dv64_pkg::word_t a;
    dv64_pkg::word_t b;
    logic            na;
    logic            nb;
    logic            sgn;
    dv64_pkg::word_t num_next;
    dv64_pkg::word_t den_next;
    dv64_pkg::ctl_t  ctl_next;

    always_comb begin
        a   = dividend[dv64_pkg::DW-1:0];
        b   = divisor[dv64_pkg::DW-1:0];
        na  = a[dv64_pkg::DW-1];
        nb  = b[dv64_pkg::DW-1];
        sgn = (mode == dv64_pkg::MODE_SQUO) || (mode == dv64_pkg::MODE_SREM);
        // magnitudes; the most negative value wraps onto itself
        num_next = (sgn && na) ? (~a + 1'b1) : a;
        den_next = (sgn && nb) ? (~b + 1'b1) : b;

        ctl_next.valid   = in_valid;
        ctl_next.sel_rem = (mode == dv64_pkg::MODE_SREM) || (mode == dv64_pkg::MODE_UREM);
        case (mode)
            dv64_pkg::MODE_SQUO: ctl_next.neg = na ^ nb;
            dv64_pkg::MODE_SREM: ctl_next.neg = na;
            default:             ctl_next.neg = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (ce) begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            num_reg <= num_next;
            den_reg <= den_next;
        end
    end

endmodule

FILE: sv/dv64_step.sv
module dv64_step (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            ce,
    input  dv64_pkg::word_t rem_in,
    input  dv64_pkg::word_t num_in,
    input  dv64_pkg::word_t den_in,
    input  dv64_pkg::ctl_t  ctl_in,
    output dv64_pkg::word_t rem_reg,
    output dv64_pkg::word_t num_reg,
    output dv64_pkg::word_t den_reg,
    output dv64_pkg::ctl_t  ctl_reg
);

    dv64_pkg::word_t         rem_sh;
    logic [dv64_pkg::DW:0]   diff;
    logic                    ge;
    dv64_pkg::word_t         rem_next;
    dv64_pkg::word_t         num_next;

    always_comb begin
        // the shift drops the top remainder bit, which is zero only while the divisor is at most half range
        rem_sh   = {rem_in[dv64_pkg::DW-2:0], num_in[dv64_pkg::DW-1]};
        diff     = {1'b0, rem_sh} - {1'b0, den_in};
        ge       = ~diff[dv64_pkg::DW];
        rem_next = ge ? diff[dv64_pkg::DW-1:0] : rem_sh;
        // dividend bits leave at the top, quotient bits come in at the bottom
        num_next = {num_in[dv64_pkg::DW-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (ce) begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            rem_reg <= rem_next;
            num_reg <= num_next;
            den_reg <= den_in;
        end
    end

endmodule

FILE: sv/dv64_post.sv
module dv64_post (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      ce,
    input  dv64_pkg::word_t           rem_in,
    input  dv64_pkg::word_t           quo_in,
    input  dv64_pkg::ctl_t            ctl_in,
    output logic                      valid_reg,
    output logic [dv64_pkg::IO_W-1:0] result_reg
);

    dv64_pkg::word_t           mag;
    dv64_pkg::word_t           res;
    logic [dv64_pkg::IO_W-1:0] result_next;

    always_comb begin
        mag         = ctl_in.sel_rem ? rem_in : quo_in;
        res         = ctl_in.neg ? (~mag + 1'b1) : mag;
        result_next = dv64_pkg::IO_W'(res);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ce) begin
            valid_reg <= ctl_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            result_reg <= result_next;
        end
    end

endmodule

FILE: sv/divider_64bit_signed_unsigned_core.sv
// channel  | ports                          | beat contents (low bit first)
// ---------+--------------------------------+----------------------------------
// input    | s_tvalid s_tready s_tdata      | tdata: dividend[63:0], divisor[127:64]
//          | s_tuser                        | tuser: mode[1:0]
// result   | m_tvalid m_tready m_tdata      | tdata: result[63:0]
//
// one beat can enter every cycle while the pipe is not held; each result goes through the
// sign stage, one restoring step stage per quotient bit, sign fix / output stage
// aresetn clears the valid bits of every stage; data registers are not reset
// when the output register holds an untaken result the whole pipe holds still,
// otherwise it moves on, with or without a beat at the input
module divider_64bit_signed_unsigned_core (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [127:0]   s_tdata,   // dividend[63:0], divisor[127:64]
    input  logic [1:0]     s_tuser,   // mode[1:0]
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [63:0]    m_tdata    // result[63:0]
);

    localparam int NS = dv64_pkg::DW;

    logic ce;

    dv64_pkg::word_t rem_s [NS+1];
    dv64_pkg::word_t num_s [NS+1];
    dv64_pkg::word_t den_s [NS+1];
    dv64_pkg::ctl_t  ctl_s [NS+1];

    assign ce       = ~m_tvalid | m_tready;
    assign s_tready = ce;
    assign rem_s[0] = '0;

    dv64_prep u_prep (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ce       (ce),
        .in_valid (s_tvalid),
        .dividend (s_tdata[63:0]),
        .divisor  (s_tdata[127:64]),
        .mode     (s_tuser),
        .num_reg  (num_s[0]),
        .den_reg  (den_s[0]),
        .ctl_reg  (ctl_s[0])
    );

    for (genvar k = 0; k < NS; k++) begin : g_step
        dv64_step u_step (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ce      (ce),
            .rem_in  (rem_s[k]),
            .num_in  (num_s[k]),
            .den_in  (den_s[k]),
            .ctl_in  (ctl_s[k]),
            .rem_reg (rem_s[k+1]),
            .num_reg (num_s[k+1]),
            .den_reg (den_s[k+1]),
            .ctl_reg (ctl_s[k+1])
        );
    end

    dv64_post u_post (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ce         (ce),
        .rem_in     (rem_s[NS]),
        .quo_in     (num_s[NS]),
        .ctl_in     (ctl_s[NS]),
        .valid_reg  (m_tvalid),
        .result_reg (m_tdata)
    );

endmodule

FILE: bench/div64_checker.sv
`timescale 1ns / 1ps

module div64_checker (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    input  logic           s_tready,
    input  logic [127:0]   s_tdata,   // dividend[63:0], divisor[127:64]
    input  logic [1:0]     s_tuser,   // mode[1:0]
    input  logic           m_tvalid,
    input  logic           m_tready,
    input  logic [63:0]    m_tdata,   // result[63:0]
    input  logic           run_done,
    output int             fail_count,
    output int             pending
);

    typedef struct {
        dv64_pkg::word_t num;
        dv64_pkg::word_t den;
        logic [1:0]      mode;
        dv64_pkg::word_t value;
    } div_expect_t;

    div_expect_t quotient_q[$];
    div_expect_t seen;
    logic        flushed;

    initial begin
        fail_count = 0;
        pending    = 0;
        flushed    = 1'b0;
    end

    // plain restoring division, msb first
    function automatic void restore_divide(input dv64_pkg::word_t num,
                                           input dv64_pkg::word_t den,
                                           output dv64_pkg::word_t quo,
                                           output dv64_pkg::word_t rem);
        int k;
        quo = '0;
        rem = '0;
        for (k = dv64_pkg::DW - 1; k >= 0; k--) begin
            rem = {rem[dv64_pkg::DW-2:0], num[k]};
            if (rem >= den) begin
                rem    = rem - den;
                quo[k] = 1'b1;
            end
        end
    endfunction

    function automatic dv64_pkg::word_t divide_result(input dv64_pkg::word_t num,
                                                      input dv64_pkg::word_t den,
                                                      input logic [1:0] mode);
        dv64_pkg::word_t quo;
        dv64_pkg::word_t rem;
        dv64_pkg::word_t mag_n;
        dv64_pkg::word_t mag_d;
        logic            neg_n;
        logic            neg_d;
        if (mode == dv64_pkg::MODE_UQUO || mode == dv64_pkg::MODE_UREM) begin
            restore_divide(num, den, quo, rem);
            return (mode == dv64_pkg::MODE_UQUO) ? quo : rem;
        end
        neg_n = num[dv64_pkg::DW-1];
        neg_d = den[dv64_pkg::DW-1];
        mag_n = neg_n ? dv64_pkg::word_t'(-num) : num;
        mag_d = neg_d ? dv64_pkg::word_t'(-den) : den;
        restore_divide(mag_n, mag_d, quo, rem);
        if (mode == dv64_pkg::MODE_SQUO)
            return (neg_n != neg_d) ? dv64_pkg::word_t'(-quo) : quo;
        return neg_n ? dv64_pkg::word_t'(-rem) : rem;
    endfunction

    task automatic report_mismatch(input string what, input div_expect_t e,
                                   input dv64_pkg::word_t got);
        fail_count++;
        $display("%0t %s: %h / %h mode %0d got %h want %h",
                 $time, what, e.num, e.den, e.mode, got, e.value);
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            // result side first so a beat never meets its own expectation
            if (m_tvalid && m_tready) begin
                if (quotient_q.size() == 0) begin
                    seen = '{default: '0};
                    report_mismatch("result with nothing expected", seen,
                                    m_tdata[dv64_pkg::DW-1:0]);
                end else begin
                    seen = quotient_q.pop_front();
                    if (m_tdata[dv64_pkg::DW-1:0] !== seen.value)
                        report_mismatch("wrong result", seen, m_tdata[dv64_pkg::DW-1:0]);
                end
            end
            if (s_tvalid && s_tready) begin
                seen.num   = s_tdata[dv64_pkg::DW-1:0];
                seen.den   = s_tdata[dv64_pkg::IO_W +: dv64_pkg::DW];
                seen.mode  = s_tuser;
                seen.value = divide_result(seen.num, seen.den, seen.mode);
                quotient_q.push_back(seen);
            end
            if (run_done && !flushed) begin
                flushed = 1'b1;
                foreach (quotient_q[i])
                    report_mismatch("result never arrived", quotient_q[i], '0);
                quotient_q.delete();
            end
            pending = quotient_q.size();
        end
    end

endmodule

FILE: bench/tb_divider_64bit_signed_unsigned_core.sv
`timescale 1ns / 1ps

module tb_divider_64bit_signed_unsigned_core;

    localparam int              RANDOM_ITEMS = 2000;
    localparam int              HOLD_AT      = 500;
    localparam int              CALM_FROM    = 1700;
    localparam int              HOLD_CYCLES  = 300;
    localparam int              STALL_LIMIT  = 5000;
    localparam dv64_pkg::word_t MOST_NEG     = {1'b1, {(dv64_pkg::DW-1){1'b0}}};
    localparam dv64_pkg::word_t MOST_POS     = {1'b0, {(dv64_pkg::DW-1){1'b1}}};
    localparam dv64_pkg::word_t ALL_ONES     = '1;

    logic           aclk = 1'b0;
    logic           aresetn = 1'b0;
    logic           s_tvalid = 1'b0;
    logic           s_tready;
    logic [127:0]   s_tdata = '0;   // dividend[63:0], divisor[127:64]
    logic [1:0]     s_tuser = '0;   // mode[1:0]
    logic           m_tvalid;
    logic           m_tready = 1'b0;
    logic [63:0]    m_tdata;        // result[63:0]
    logic           run_done = 1'b0;
    int             fail_count;
    int             pending;

    bit             calm = 1'b0;
    bit             hold_req = 1'b0;
    bit             gaps_on = 1'b1;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    divider_64bit_signed_unsigned_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    div64_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .run_done   (run_done),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // offer one beat from a falling edge and return at the falling edge after it is taken
    task automatic send_division(input dv64_pkg::word_t num, input dv64_pkg::word_t den,
                                 input logic [1:0] mode);
        s_tdata  <= {den, num};
        s_tuser  <= mode;
        s_tvalid <= 1'b1;
        do
            @(posedge aclk);
        while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic sender_gap();
        int n;
        n = $urandom_range(1, 11);
        s_tvalid <= 1'b0;
        repeat (n) @(negedge aclk);
    endtask

    function automatic dv64_pkg::word_t pick_operand();
        dv64_pkg::word_t w;
        w = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            3, 4: w = w >> $urandom_range(0, dv64_pkg::DW - 1);
            5:    w = -(w >> $urandom_range(1, dv64_pkg::DW - 1));
            6:    w = dv64_pkg::word_t'($urandom_range(0, 15));
            7:    w = -dv64_pkg::word_t'($urandom_range(1, 15));
            8: begin
                case ($urandom_range(0, 4))
                    0:       w = MOST_NEG;
                    1:       w = MOST_POS;
                    2:       w = ALL_ONES;
                    3:       w = '0;
                    default: w = dv64_pkg::word_t'(1) << $urandom_range(0, dv64_pkg::DW - 1);
                endcase
            end
            9:    w = w | MOST_NEG;
            default: ;
        endcase
        return w;
    endfunction

    // receiver: random stall bursts, one long hold on request, none once calm
    initial begin
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
                hold_req = 1'b0;
            end else if (calm || $urandom_range(0, 5) != 0) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 11) - 1) @(negedge aclk);
            end
        end
    end

    // watchdog on cycles with no beat on either side
    initial begin
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("divider_64bit_signed_unsigned_core test failed");
        $finish;
    end

    initial begin
        dv64_pkg::word_t num;
        dv64_pkg::word_t den;
        logic [1:0]      mode;

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // most negative over minus one in every mode; the signed quotient wraps
        send_division(MOST_NEG, ALL_ONES, dv64_pkg::MODE_SQUO);
        send_division(MOST_NEG, ALL_ONES, dv64_pkg::MODE_SREM);
        send_division(MOST_NEG, ALL_ONES, dv64_pkg::MODE_UQUO);
        send_division(MOST_NEG, ALL_ONES, dv64_pkg::MODE_UREM);
        // division by zero
        send_division(dv64_pkg::word_t'(5), '0, dv64_pkg::MODE_SQUO);
        send_division(-dv64_pkg::word_t'(5), '0, dv64_pkg::MODE_SQUO);
        send_division(-dv64_pkg::word_t'(5), '0, dv64_pkg::MODE_SREM);
        send_division(dv64_pkg::word_t'(5), '0, dv64_pkg::MODE_UQUO);
        send_division(dv64_pkg::word_t'(5), '0, dv64_pkg::MODE_UREM);
        send_division('0, '0, dv64_pkg::MODE_SQUO);
        // sign handling of quotient and remainder
        send_division(-dv64_pkg::word_t'(7), dv64_pkg::word_t'(2), dv64_pkg::MODE_SQUO);
        send_division(-dv64_pkg::word_t'(7), dv64_pkg::word_t'(2), dv64_pkg::MODE_SREM);
        send_division(dv64_pkg::word_t'(7), -dv64_pkg::word_t'(2), dv64_pkg::MODE_SQUO);
        send_division(dv64_pkg::word_t'(7), -dv64_pkg::word_t'(2), dv64_pkg::MODE_SREM);
        send_division(-dv64_pkg::word_t'(7), -dv64_pkg::word_t'(2), dv64_pkg::MODE_SQUO);
        // field extremes
        send_division(ALL_ONES, dv64_pkg::word_t'(1), dv64_pkg::MODE_UQUO);
        send_division(ALL_ONES, ALL_ONES, dv64_pkg::MODE_UREM);
        send_division(MOST_POS, MOST_NEG, dv64_pkg::MODE_SQUO);
        send_division(MOST_NEG, MOST_NEG, dv64_pkg::MODE_SREM);
        send_division(dv64_pkg::word_t'(1), ALL_ONES, dv64_pkg::MODE_UQUO);
        send_division(ALL_ONES, dv64_pkg::word_t'(2), dv64_pkg::MODE_UREM);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == CALM_FROM)
                calm = 1'b1;
            if (i % 64 == 0)
                gaps_on = ($urandom_range(0, 2) != 0);
            // receiver holds off while the sender keeps pushing, so the pipe backs up
            if (i == HOLD_AT)
                hold_req = 1'b1;
            den  = pick_operand();
            num  = pick_operand();
            mode = 2'($urandom_range(0, 3));
            if ($urandom_range(0, 4) == 0)
                num = den * dv64_pkg::word_t'($urandom_range(0, 1000))
                      + dv64_pkg::word_t'($urandom_range(0, 3));
            if (!calm && gaps_on && !hold_req && $urandom_range(0, 4) == 0)
                sender_gap();
            send_division(num, den, mode);
        end
        s_tvalid <= 1'b0;

        while (pending != 0)
            @(negedge aclk);
        repeat (dv64_pkg::DW + 8) @(negedge aclk);
        run_done = 1'b1;
        repeat (2) @(negedge aclk);

        if (fail_count == 0)
            $display("divider_64bit_signed_unsigned_core test passed");
        else
            $display("divider_64bit_signed_unsigned_core test failed");
        $finish;
    end

endmodule
